/* hw/rtl/pev_pkg.sv */
// ----------------------------------------------------------------------------
// pev_pkg
// Shared types and constants of the prefix expression stack evaluator.
// ----------------------------------------------------------------------------
package pev_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // character codes
  localparam logic [7:0] CH_DIGIT_BASE = 8'd48;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_CARET      = 8'h5E;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_DIV_ZERO  = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW,
    OP_ONE
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_B,
    S_POP_A,
    S_EXEC,
    S_WAIT,
    S_READ,
    S_EMIT
  } ctl_state_t;

  typedef enum logic [2:0] {
    AL_IDLE,
    AL_ADD,
    AL_MUL,
    AL_DIV,
    AL_FIX,
    AL_DONE
  } alu_state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

/* hw/rtl/pev_alu.sv */
// ----------------------------------------------------------------------------
// pev_alu
// Serial arithmetic unit: bit-serial add and subtract, shift-add multiply
// and square-and-multiply power one multiplier bit per cycle, restoring
// divide one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pev_alu #(
  parameter int VALUE_WIDTH = pev_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pev_pkg::alu_req_t      req,
  input  logic [VALUE_WIDTH-1:0] opnd_b,
  input  logic [VALUE_WIDTH-1:0] opnd_a,
  output pev_pkg::alu_rsp_t      rsp,
  output logic [VALUE_WIDTH-1:0] result
);

  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

  pev_pkg::alu_state_t state_r, state_nxt;

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   carry_r, carry_nxt;
  logic [VALUE_WIDTH-1:0] x_r, x_nxt;
  logic [VALUE_WIDTH-1:0] y_r, y_nxt;
  logic [VALUE_WIDTH-1:0] md_r, md_nxt;
  logic [VALUE_WIDTH-1:0] m1_r, m1_nxt;
  logic [VALUE_WIDTH-1:0] m2_r, m2_nxt;
  logic [VALUE_WIDTH-1:0] acc1_r, acc1_nxt;
  logic [VALUE_WIDTH-1:0] acc2_r, acc2_nxt;
  logic [VALUE_WIDTH-1:0] pr_r, pr_nxt;
  logic [VALUE_WIDTH-1:0] exp_r, exp_nxt;
  logic                   pow_r, pow_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] den_r, den_nxt;
  logic                   neg_r, neg_nxt;
  logic [VALUE_WIDTH-1:0] res_r, res_nxt;
  logic                   dz_r, dz_nxt;

  logic                   sum_bit;
  logic                   carry_out;
  logic [VALUE_WIDTH-1:0] acc1_add;
  logic [VALUE_WIDTH-1:0] acc2_add;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH-1:0] mag_b;
  logic [VALUE_WIDTH-1:0] mag_a;
  logic [VALUE_WIDTH-1:0] pr_new;
  logic [VALUE_WIDTH-1:0] exp_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pev_pkg::AL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    carry_r <= carry_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    md_r    <= md_nxt;
    m1_r    <= m1_nxt;
    m2_r    <= m2_nxt;
    acc1_r  <= acc1_nxt;
    acc2_r  <= acc2_nxt;
    pr_r    <= pr_nxt;
    exp_r   <= exp_nxt;
    pow_r   <= pow_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    neg_r   <= neg_nxt;
    res_r   <= res_nxt;
    dz_r    <= dz_nxt;
  end

  // datapath pieces
  always_comb begin
    sum_bit   = x_r[0] ^ y_r[0] ^ carry_r;
    carry_out = (x_r[0] & y_r[0]) | (carry_r & (x_r[0] ^ y_r[0]));
    acc1_add  = acc1_r + (m1_r[0] ? md_r : '0);
    acc2_add  = acc2_r + (m2_r[0] ? md_r : '0);
    trial     = {rem_r, x_r[VALUE_WIDTH-1]} - {1'b0, den_r};
    mag_b     = opnd_b[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - opnd_b) : opnd_b;
    mag_a     = opnd_a[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - opnd_a) : opnd_a;
    pr_new    = exp_r[0] ? acc1_add : pr_r;
    exp_new   = exp_r >> 1;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    carry_nxt = carry_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    md_nxt    = md_r;
    m1_nxt    = m1_r;
    m2_nxt    = m2_r;
    acc1_nxt  = acc1_r;
    acc2_nxt  = acc2_r;
    pr_nxt    = pr_r;
    exp_nxt   = exp_r;
    pow_nxt   = pow_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    dz_nxt    = dz_r;

    rsp.done     = (state_r == pev_pkg::AL_DONE);
    rsp.div_zero = dz_r;
    result       = res_r;

    unique case (state_r)
      pev_pkg::AL_IDLE: begin
        if (req.start) begin
          dz_nxt  = 1'b0;
          cnt_nxt = CNT_LAST;
          unique case (req.op)
            pev_pkg::OP_ADD: begin
              x_nxt     = opnd_b;
              y_nxt     = opnd_a;
              carry_nxt = 1'b0;
              state_nxt = pev_pkg::AL_ADD;
            end
            pev_pkg::OP_SUB: begin
              x_nxt     = opnd_b;
              y_nxt     = ~opnd_a;
              carry_nxt = 1'b1;
              state_nxt = pev_pkg::AL_ADD;
            end
            pev_pkg::OP_MUL: begin
              md_nxt    = opnd_b;
              m1_nxt    = opnd_a;
              m2_nxt    = '0;
              acc1_nxt  = '0;
              acc2_nxt  = '0;
              pow_nxt   = 1'b0;
              state_nxt = pev_pkg::AL_MUL;
            end
            pev_pkg::OP_POW: begin
              if (opnd_a == '0 || opnd_a[VALUE_WIDTH-1]) begin
                res_nxt   = VALUE_WIDTH'(1);
                state_nxt = pev_pkg::AL_DONE;
              end else begin
                md_nxt    = opnd_b;
                m1_nxt    = VALUE_WIDTH'(1);
                m2_nxt    = opnd_b;
                acc1_nxt  = '0;
                acc2_nxt  = '0;
                pr_nxt    = VALUE_WIDTH'(1);
                exp_nxt   = opnd_a;
                pow_nxt   = 1'b1;
                state_nxt = pev_pkg::AL_MUL;
              end
            end
            pev_pkg::OP_DIV: begin
              if (opnd_a == '0) begin
                res_nxt   = '0;
                dz_nxt    = 1'b1;
                state_nxt = pev_pkg::AL_DONE;
              end else begin
                x_nxt     = mag_b;
                den_nxt   = mag_a;
                rem_nxt   = '0;
                neg_nxt   = opnd_b[VALUE_WIDTH-1] ^ opnd_a[VALUE_WIDTH-1];
                state_nxt = pev_pkg::AL_DIV;
              end
            end
            pev_pkg::OP_ONE: begin
              res_nxt   = VALUE_WIDTH'(1);
              state_nxt = pev_pkg::AL_DONE;
            end
            default: begin
              res_nxt   = VALUE_WIDTH'(1);
              state_nxt = pev_pkg::AL_DONE;
            end
          endcase
        end
      end

      // one sum bit per cycle, lsb first
      pev_pkg::AL_ADD: begin
        x_nxt     = {sum_bit, x_r[VALUE_WIDTH-1:1]};
        y_nxt     = y_r >> 1;
        carry_nxt = carry_out;
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          res_nxt   = {sum_bit, x_r[VALUE_WIDTH-1:1]};
          state_nxt = pev_pkg::AL_DONE;
        end
      end

      // acc1 builds m1 * md, acc2 builds the square for power
      pev_pkg::AL_MUL: begin
        acc1_nxt = acc1_add;
        acc2_nxt = acc2_add;
        md_nxt   = md_r << 1;
        m1_nxt   = m1_r >> 1;
        m2_nxt   = m2_r >> 1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          if (!pow_r) begin
            res_nxt   = acc1_add;
            state_nxt = pev_pkg::AL_DONE;
          end else if (exp_new == '0) begin
            res_nxt   = pr_new;
            state_nxt = pev_pkg::AL_DONE;
          end else begin
            pr_nxt   = pr_new;
            exp_nxt  = exp_new;
            md_nxt   = acc2_add;
            m1_nxt   = pr_new;
            m2_nxt   = acc2_add;
            acc1_nxt = '0;
            acc2_nxt = '0;
            cnt_nxt  = CNT_LAST;
          end
        end
      end

      // restoring divide on magnitudes
      pev_pkg::AL_DIV: begin
        if (!trial[VALUE_WIDTH]) begin
          rem_nxt = trial[VALUE_WIDTH-1:0];
          x_nxt   = {x_r[VALUE_WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[VALUE_WIDTH-2:0], x_r[VALUE_WIDTH-1]};
          x_nxt   = {x_r[VALUE_WIDTH-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = pev_pkg::AL_FIX;
        end
      end

      pev_pkg::AL_FIX: begin
        res_nxt   = neg_r ? (VALUE_WIDTH'(0) - x_r) : x_r;
        state_nxt = pev_pkg::AL_DONE;
      end

      pev_pkg::AL_DONE: begin
        state_nxt = pev_pkg::AL_IDLE;
      end

      default: begin
        state_nxt = pev_pkg::AL_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/prefix_expression_stack_evaluator_unit.sv */
// ----------------------------------------------------------------------------
// prefix_expression_stack_evaluator_unit
// Evaluates a prefix expression fed one character per beat, last character
// first, on an operand stack held in a memory.
// ----------------------------------------------------------------------------
// An operand character is pushed as its code minus 48. An operator pops
// its operands from the stack memory (one read port, registered read data)
// in S_POP_B and S_POP_A, starts the serial unit in S_EXEC, waits in
// S_WAIT and pushes the result; a parenthesis takes this path and pushes 1.
// For / the unit adds a sign fix-up step, and for ^ it makes one multiply
// pass per exponent bit up to the highest set bit, giving 1 with no pass
// for a zero or negative exponent. The serial unit works one bit per cycle.
// A beat marked last then reads the top of the stack (S_READ) and loads the
// output register (S_EMIT), after any wait for the previous result to be
// taken. The stack needs no clearing after reset.
// ----------------------------------------------------------------------------
module prefix_expression_stack_evaluator_unit #(
  parameter int STACK_DEPTH = pev_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = pev_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_symbol,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output logic [1:0]                    out_status
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  pev_pkg::ctl_state_t state_r, state_nxt;

  logic [CNT_W-1:0]       count_r, count_nxt;
  pev_pkg::status_t       err_r, err_nxt;
  logic                   last_r, last_nxt;
  pev_pkg::alu_op_t       op_r, op_nxt;
  logic [VALUE_WIDTH-1:0] b_r, b_nxt;
  logic [VALUE_WIDTH-1:0] a_r, a_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] out_value_r, out_value_nxt;
  pev_pkg::status_t       out_status_r, out_status_nxt;

  logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   wr_en;
  logic [VALUE_WIDTH-1:0] wr_data;

  logic                   in_is_op;
  pev_pkg::alu_op_t       in_op;
  logic [8:0]             digit_diff;
  logic [VALUE_WIDTH-1:0] push_val;
  logic                   out_load;

  pev_pkg::alu_req_t      alu_req;
  pev_pkg::alu_rsp_t      alu_rsp;
  logic [VALUE_WIDTH-1:0] alu_result;

  function automatic pev_pkg::status_t note_err(pev_pkg::status_t cur,
                                                pev_pkg::status_t code);
    return (cur == pev_pkg::STAT_OK) ? code : cur;
  endfunction

  pev_alu #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opnd_b (b_r),
    .opnd_a (a_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  // stack memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[count_r[ADDR_W-1:0]] <= wr_data;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pev_pkg::S_IDLE;
      count_r     <= '0;
      err_r       <= pev_pkg::STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r       <= last_nxt;
    op_r         <= op_nxt;
    b_r          <= b_nxt;
    a_r          <= a_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // symbol decode
  always_comb begin
    in_is_op   = 1'b1;
    in_op      = pev_pkg::OP_ONE;
    digit_diff = {1'b0, in_symbol} - {1'b0, pev_pkg::CH_DIGIT_BASE};
    push_val   = VALUE_WIDTH'(signed'(digit_diff));
    unique case (in_symbol)
      pev_pkg::CH_PLUS:   in_op = pev_pkg::OP_ADD;
      pev_pkg::CH_MINUS:  in_op = pev_pkg::OP_SUB;
      pev_pkg::CH_STAR:   in_op = pev_pkg::OP_MUL;
      pev_pkg::CH_SLASH:  in_op = pev_pkg::OP_DIV;
      pev_pkg::CH_CARET:  in_op = pev_pkg::OP_POW;
      pev_pkg::CH_LPAREN: in_op = pev_pkg::OP_ONE;
      pev_pkg::CH_RPAREN: in_op = pev_pkg::OP_ONE;
      default:            in_is_op = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    err_nxt        = err_r;
    last_nxt       = last_r;
    op_nxt         = op_r;
    b_nxt          = b_r;
    a_nxt          = a_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_load       = 1'b0;
    in_ready       = (state_r == pev_pkg::S_IDLE);
    wr_en          = 1'b0;
    wr_data        = push_val;
    rd_addr        = ADDR_W'(count_r - CNT_W'(1));
    alu_req.start  = 1'b0;
    alu_req.op     = op_r;

    unique case (state_r)
      pev_pkg::S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last;
          if (in_is_op) begin
            op_nxt    = in_op;
            state_nxt = pev_pkg::S_POP_B;
          end else begin
            if (count_r < DEPTH_CNT) begin
              wr_en     = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              err_nxt = note_err(err_r, pev_pkg::STAT_OVERFLOW);
            end
            state_nxt = in_last ? pev_pkg::S_READ : pev_pkg::S_IDLE;
          end
        end
      end

      // top was read while idle; fetch the entry below it
      pev_pkg::S_POP_B: begin
        rd_addr = ADDR_W'(count_r - CNT_W'(2));
        if (count_r != '0) begin
          b_nxt     = rd_data_r;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          b_nxt   = '0;
          err_nxt = note_err(err_r, pev_pkg::STAT_UNDERFLOW);
        end
        state_nxt = pev_pkg::S_POP_A;
      end

      pev_pkg::S_POP_A: begin
        if (count_r != '0) begin
          a_nxt     = rd_data_r;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          a_nxt   = '0;
          err_nxt = note_err(err_r, pev_pkg::STAT_UNDERFLOW);
        end
        state_nxt = pev_pkg::S_EXEC;
      end

      pev_pkg::S_EXEC: begin
        alu_req.start = 1'b1;
        state_nxt     = pev_pkg::S_WAIT;
      end

      pev_pkg::S_WAIT: begin
        if (alu_rsp.done) begin
          wr_data = alu_result;
          if (alu_rsp.div_zero) begin
            err_nxt = note_err(err_r, pev_pkg::STAT_DIV_ZERO);
          end
          if (count_r < DEPTH_CNT) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            err_nxt = note_err(err_nxt, pev_pkg::STAT_OVERFLOW);
          end
          state_nxt = last_r ? pev_pkg::S_READ : pev_pkg::S_IDLE;
        end
      end

      pev_pkg::S_READ: begin
        state_nxt = pev_pkg::S_EMIT;
      end

      pev_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_value_nxt = (count_r != '0) ? rd_data_r : '0;
          if (count_r == '0 && err_r == pev_pkg::STAT_OK) begin
            out_status_nxt = pev_pkg::STAT_UNDERFLOW;
          end else begin
            out_status_nxt = err_r;
          end
          count_nxt = '0;
          err_nxt   = pev_pkg::STAT_OK;
          state_nxt = pev_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pev_pkg::S_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_ready) || out_load;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = $signed(out_value_r);
  assign out_status = out_status_r;

  // stack fill never passes the depth
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= DEPTH_CNT)
    else $error("stack count beyond depth");

  // an operand beat with room grows the stack by one
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_is_op && count_r < DEPTH_CNT)
      |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("operand beat did not push");

  // a recorded error holds until the result is loaded
  assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != pev_pkg::STAT_OK && !out_load) |=> err_r == $past(err_r))
    else $error("sticky error changed");

  // the serial unit only finishes while the controller waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == pev_pkg::S_WAIT)
    else $error("unit finished outside wait");

  // loading a result empties the stack, clears the error and raises out_valid
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (count_r == '0 && err_r == pev_pkg::STAT_OK && out_valid_r))
    else $error("stack not cleared after result");

endmodule
